### sv/tfp_pkg.sv
// tfp_pkg: shared types and constants of the telemetry frame packer
// no dependencies; used by every module of the block
package tfp_pkg;

  // frame geometry and defaults
  localparam int MAX_WORDS_DEF = 16;
  localparam int WC_W          = 5;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION = 2'd2;

  // register reset values
  localparam logic [7:0] HEADER_RST   = 8'hAB;
  localparam logic [7:0] TARGET_RST   = 8'hFF;
  localparam logic [7:0] FUNCTION_RST = 8'hF1;

  // input word
  typedef struct packed {
    logic signed [31:0]    value;
    logic [WC_W-1:0]       word_count;
  } in_item_t;

  // output word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_item;
    logic       last_of_frame;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  len_byte;
    logic        first;
    logic        empty;
    logic        last;
  } desc_t;

  // frame constants seen by the serializer
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] target_address;
    logic [7:0] function_id;
  } cfg_t;

endpackage

### sv/tfp_front.sv
// tfp_front: accepts input words, tracks the open frame and classifies each word
// depends on tfp_pkg
module tfp_front #(
  parameter int MAX_WORDS = tfp_pkg::MAX_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfp_pkg::in_item_t in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output tfp_pkg::desc_t    desc_o
);

  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int XW = (CW > tfp_pkg::WC_W) ? CW : tfp_pkg::WC_W;

  logic [CW-1:0] words_left_q, words_left_d;
  logic [XW-1:0] wc_x, max_x, sat_x;
  logic [CW-1:0] count;
  logic          open_frame;

  // saturate the sampled word count
  assign wc_x  = XW'(in_data_i.word_count);
  assign max_x = XW'(MAX_WORDS);
  assign sat_x = (wc_x > max_x) ? max_x : wc_x;
  assign count = CW'(sat_x);

  assign open_frame = (words_left_q != '0);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // classify the word
  always_comb begin
    desc_o.value    = in_data_i.value;
    desc_o.len_byte = 8'({count, 2'b00});
    desc_o.first    = !open_frame;
    desc_o.empty    = !open_frame && (count == '0);
    if (open_frame) begin
      desc_o.last  = (words_left_q == CW'(1));
      words_left_d = words_left_q - CW'(1);
    end else begin
      desc_o.last  = (count <= CW'(1));
      words_left_d = (count == '0) ? '0 : count - CW'(1);
    end
  end

  // words still owed to the open frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= '0;
    end else if (push_o) begin
      words_left_q <= words_left_d;
    end
  end

endmodule

### sv/tfp_queue.sv
// tfp_queue: short register queue between front and back
// depends on tfp_pkg
module tfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfp_pkg::desc_t desc_i,
  output logic           full_o,
  output logic           head_valid_o,
  output tfp_pkg::desc_t head_o,
  input  logic           pop_i
);

  localparam int DEPTH = tfp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  tfp_pkg::desc_t slot_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  fill_q;

  assign full_o       = (fill_q == NW'(DEPTH));
  assign head_valid_o = (fill_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + NW'(1);
        2'b01:   fill_q <= fill_q - NW'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### sv/tfp_back.sv
// tfp_back: byte serializer with running checks and output register
// depends on tfp_pkg
module tfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfp_pkg::cfg_t      cfg_i,
  input  logic               head_valid_i,
  input  tfp_pkg::desc_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tfp_pkg::out_item_t out_data_o
);

  typedef enum logic [3:0] {
    PH_NEW, PH_HDR, PH_ADDR, PH_FID, PH_LEN,
    PH_D0, PH_D1, PH_D2, PH_D3, PH_SUM, PH_ADD
  } phase_e;

  phase_e             phase_q, phase_d, cur;
  logic [7:0]         sum_q, add_q, sum_d, add_d;
  logic               out_valid_q;
  tfp_pkg::out_item_t out_q;
  logic               adv, done, checked;
  logic [7:0]         byte_v;

  assign adv = head_valid_i && (!out_valid_q || !out_stall_i);
  assign cur = (phase_q == PH_NEW) ? (head_i.first ? PH_HDR : PH_D0) : phase_q;

  // byte select and next phase
  always_comb begin
    byte_v  = 8'h00;
    checked = 1'b1;
    done    = 1'b0;
    phase_d = cur;
    unique case (cur)
      PH_HDR:  begin byte_v = cfg_i.header_byte;    phase_d = PH_ADDR; end
      PH_ADDR: begin byte_v = cfg_i.target_address; phase_d = PH_FID;  end
      PH_FID:  begin byte_v = cfg_i.function_id;    phase_d = PH_LEN;  end
      PH_LEN:  begin
        byte_v  = head_i.len_byte;
        phase_d = head_i.empty ? PH_SUM : PH_D0;
      end
      PH_D0:   begin byte_v = head_i.value[7:0];    phase_d = PH_D1;   end
      PH_D1:   begin byte_v = head_i.value[15:8];   phase_d = PH_D2;   end
      PH_D2:   begin byte_v = head_i.value[23:16];  phase_d = PH_D3;   end
      PH_D3:   begin
        byte_v  = head_i.value[31:24];
        done    = !head_i.last;
        phase_d = head_i.last ? PH_SUM : PH_NEW;
      end
      PH_SUM:  begin byte_v = sum_q; checked = 1'b0; phase_d = PH_ADD; end
      PH_ADD:  begin
        byte_v  = add_q;
        checked = 1'b0;
        done    = 1'b1;
        phase_d = PH_NEW;
      end
      default: begin byte_v = 8'h00; phase_d = PH_NEW; end
    endcase
  end

  // running sum and add checks, restarted by the header
  always_comb begin
    if (cur == PH_HDR) begin
      sum_d = byte_v;
      add_d = byte_v;
    end else if (cur == PH_ADD) begin
      sum_d = 8'h00;
      add_d = 8'h00;
    end else if (checked) begin
      sum_d = sum_q + byte_v;
      add_d = add_q + sum_d;
    end else begin
      sum_d = sum_q;
      add_d = add_q;
    end
  end

  assign pop_o       = adv && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NEW;
      sum_q       <= 8'h00;
      add_q       <= 8'h00;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (adv) begin
        phase_q             <= phase_d;
        sum_q               <= sum_d;
        add_q               <= add_d;
        out_valid_q         <= 1'b1;
        out_q.frame_byte    <= byte_v;
        out_q.last_of_item  <= done;
        out_q.last_of_frame <= (cur == PH_ADD);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### sv/telemetry_frame_packer.sv
// telemetry_frame_packer: top level, configuration registers and the three parts
// depends on tfp_pkg, tfp_front, tfp_queue, tfp_back
// path: an accepted word goes into a queue slot; with the serializer idle, its first byte
//   goes into the output register; throughput is one byte per cycle from the serializer
//   while a word is queued and the output is not stalled: a mid-frame word is 4 bytes,
//   a frame's first word 8, an empty frame 6, plus 2 check bytes on the last word
// reset: no frame open, checks cleared, registers at 0xAB, 0xFF, 0xF1, queue empty
module telemetry_frame_packer #(
  parameter int MAX_WORDS = tfp_pkg::MAX_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tfp_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tfp_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tfp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  tfp_pkg::cfg_t  cfg_q;
  tfp_pkg::desc_t push_desc, head_desc;
  logic           push, full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte    <= tfp_pkg::HEADER_RST;
      cfg_q.target_address <= tfp_pkg::TARGET_RST;
      cfg_q.function_id    <= tfp_pkg::FUNCTION_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tfp_pkg::REG_HEADER:   cfg_q.header_byte    <= cfg_data_i;
        tfp_pkg::REG_TARGET:   cfg_q.target_address <= cfg_data_i;
        tfp_pkg::REG_FUNCTION: cfg_q.function_id    <= cfg_data_i;
        default:               cfg_q                <= cfg_q;
      endcase
    end
  end

  // front: accept and classify
  tfp_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  // queue between front and back
  tfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (push_desc),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_desc),
    .pop_i        (pop)
  );

  // back: serialize bytes
  tfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for telemetry_frame_packer, frame bytes against a predictor
// depends on tfp_pkg and the telemetry_frame_packer rtl
module testbench;
  import tfp_pkg::*;

  localparam int MAX_WORDS    = MAX_WORDS_DEF;
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 40;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // frame predictor and the bytes still owed by the block
  class frame_tracker;
    logic [7:0] header_b, target_b, function_b;
    logic [4:0] words_left;
    logic [7:0] sum_chk, add_chk;
    out_item_t  due_bytes[$];
    int         errors, bytes_seen, frames_seen, words_seen;

    function new();
      header_b    = HEADER_RST;
      target_b    = TARGET_RST;
      function_b  = FUNCTION_RST;
      words_left  = '0;
      sum_chk     = '0;
      add_chk     = '0;
      errors      = 0;
      bytes_seen  = 0;
      frames_seen = 0;
      words_seen  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
      case (idx)
        REG_HEADER:   header_b = d;
        REG_TARGET:   target_b = d;
        REG_FUNCTION: function_b = d;
        default: ;
      endcase
    endfunction

    // one byte of the frame, optionally folded into both checks
    function void add_byte(logic [7:0] b, bit summed);
      out_item_t e;
      if (summed) begin
        sum_chk = sum_chk + b;
        add_chk = add_chk + sum_chk;
      end
      e.frame_byte    = b;
      e.last_of_item  = 1'b0;
      e.last_of_frame = 1'b0;
      due_bytes.push_back(e);
    endfunction

    function void add_data(logic [31:0] v);
      for (int k = 0; k < 4; k++) add_byte(v[8*k +: 8], 1'b1);
    endfunction

    // sum check then add check closes the frame
    function void add_checks();
      out_item_t e;
      add_byte(sum_chk, 1'b0);
      e.frame_byte    = add_chk;
      e.last_of_item  = 1'b0;
      e.last_of_frame = 1'b1;
      due_bytes.push_back(e);
      sum_chk = '0;
      add_chk = '0;
    endfunction

    function void note_word(in_item_t w);
      logic [4:0] count;
      out_item_t  tail;
      words_seen++;
      if (words_left == 0) begin
        // frame opens: count sampled here and saturated
        count   = (w.word_count > MAX_WORDS) ? 5'(MAX_WORDS) : w.word_count;
        sum_chk = '0;
        add_chk = '0;
        add_byte(header_b, 1'b1);
        add_byte(target_b, 1'b1);
        add_byte(function_b, 1'b1);
        add_byte(8'(count) << 2, 1'b1);
        if (count == 0) begin
          add_checks();
        end else begin
          add_data(w.value);
          words_left = count - 5'd1;
          if (words_left == 0) add_checks();
        end
      end else begin
        // mid frame: only the value matters
        add_data(w.value);
        words_left = words_left - 5'd1;
        if (words_left == 0) add_checks();
      end
      tail = due_bytes.pop_back();
      tail.last_of_item = 1'b1;
      due_bytes.push_back(tail);
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want, got);
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte, expected none, got %02h item end %b frame end %b",
                   $time, got.frame_byte, got.last_of_item, got.last_of_frame);
        return;
      end
      want = due_bytes.pop_front();
      bytes_seen++;
      if (want.last_of_frame) frames_seen++;
      if (got.frame_byte !== want.frame_byte)
        report("frame_byte", want.frame_byte, got.frame_byte);
      if (got.last_of_item !== want.last_of_item)
        report("last_of_item", 8'(want.last_of_item), 8'(got.last_of_item));
      if (got.last_of_frame !== want.last_of_frame)
        report("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  frame_tracker frames;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_tog      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int cycle_cnt     = 0;

  telemetry_frame_packer #(
    .MAX_WORDS(MAX_WORDS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) frames.check_byte(out_data_o);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [31:0] v, logic [4:0] wc);
    in_item_t it;
    it.value      = v;
    it.word_count = wc;
    return it;
  endfunction

  // extremes mixed into random data
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one word after a random gap, hold it until taken
  task automatic send_word(in_item_t w);
    int gap = 0;
    while (gap < 200 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    frames.note_word(w);
  endtask

  // sender pauses until every owed byte has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frames.due_bytes.size() != 0);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.write_reg(idx, d);
  endtask

  task automatic program_regs(logic [7:0] hdr, logic [7:0] tgt, logic [7:0] fid);
    put_reg(REG_HEADER, hdr);
    put_reg(REG_TARGET, tgt);
    put_reg(REG_FUNCTION, fid);
    put_reg(REG_SPARE, 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // frames with random content, mostly short ones; the last may be cut off at n_items
  task automatic send_frames(int n_items);
    int         sent = 0;
    int         pick;
    int         words;
    logic [4:0] wc;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) wc = 5'd0;
      else if (pick < 75) wc = 5'($urandom_range(1, 4));
      else if (pick < 90) wc = 5'($urandom_range(5, 16));
      else wc = 5'($urandom_range(17, 31));
      words = (wc == 0) ? 1 : ((wc > MAX_WORDS) ? MAX_WORDS : int'(wc));
      for (int k = 0; k < words && sent < n_items; k++) begin
        send_word(mk_item(rand_value(), (k == 0) ? wc : 5'($urandom_range(0, 31))));
        sent++;
      end
    end
  endtask

  initial begin
    frames = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty frame, single-word extremes, ignored mid-frame count, saturation
    send_word(mk_item($urandom, 5'd0));
    send_word(mk_item(32'h8000_0000, 5'd1));
    send_word(mk_item(32'h7FFF_FFFF, 5'd1));
    send_word(mk_item(32'h0000_0000, 5'd2));
    send_word(mk_item(32'hFFFF_FFFF, 5'd0));
    send_word(mk_item(32'hA5A5_5A5A, 5'd31));
    for (int k = 1; k < MAX_WORDS; k++)
      send_word(mk_item(rand_value(), 5'($urandom_range(0, 31))));
    drain();

    // no idling, low register extremes
    program_regs(8'h00, 8'h00, 8'hFA);
    send_frames(80);
    drain();

    // sender mostly idle, high extremes and a function id out of range
    program_regs(8'hFF, 8'hFF, 8'h00);
    snd_idle_pct = 88;
    send_frames(80);
    drain();

    // receiver mostly stalled
    snd_idle_pct = 0;
    rcv_stall_pct <= 88;
    program_regs(8'($urandom), 8'($urandom), 8'hFF);
    send_frames(80);

    // long hold-off while words keep coming, input must back up
    rcv_stall_pct <= 0;
    hold_tog <= ~hold_tog;
    send_frames(30);
    drain();

    // light idling on both sides
    snd_idle_pct = 10;
    rcv_stall_pct <= 10;
    program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(241, 250)));
    send_frames(70);
    drain();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d words in %0d closed frames, %0d bytes checked",
             frames.words_seen, frames.frames_seen, frames.bytes_seen);
    $display("register settings: reset, low and high extremes, random; idling and hold-off");
    if (frames.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
sv/tfp_pkg.sv
sv/tfp_front.sv
sv/tfp_queue.sv
sv/tfp_back.sv
sv/telemetry_frame_packer.sv
tb/sv/testbench.sv
